>>> sv/asd_pkg.sv
`default_nettype none
package asd_pkg;

  localparam int unsigned TimeW   = 63;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned DistW   = 24;
  localparam int unsigned DurW    = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 40;

  localparam logic [CfgIdxW-1:0] CfgStopSpeed  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRearmSpeed = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGoalLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHoldTime   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRearmTime  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGraceTime  = 3'd5;

  localparam logic [MagW-1:0]  StopSpeedRst  = 15'd26;
  localparam logic [MagW-1:0]  RearmSpeedRst = 15'd256;
  localparam logic [DistW-1:0] GoalLimitRst  = 24'd160;
  localparam logic [DurW-1:0]  HoldTimeRst   = 40'd5000000000;
  localparam logic [DurW-1:0]  RearmTimeRst  = 40'd2000000000;
  localparam logic [DurW-1:0]  GraceTimeRst  = 40'd3000000000;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic [MagW-1:0]  stop_speed;
    logic [MagW-1:0]  rearm_speed;
    logic [DistW-1:0] goal_distance_limit;
    logic [DurW-1:0]  hold_time;
    logic [DurW-1:0]  rearm_time;
    logic [DurW-1:0]  grace_time;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        now_time;
    logic signed [SpeedW-1:0] speed;
    logic [DistW-1:0]        goal_distance;
    logic                    autonomous;
    logic                    at_goal;
    logic                    plan_stop;
    logic                    data_fresh;
  } sample_t;

endpackage
`default_nettype wire

>>> sv/asd_ifs.sv
`default_nettype none
interface asd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [asd_pkg::TimeW-1:0]             now_time;
  logic signed [asd_pkg::SpeedW-1:0]     speed;
  logic [asd_pkg::DistW-1:0]             goal_distance;
  logic                                  autonomous;
  logic                                  at_goal;
  logic                                  plan_stop;
  logic                                  data_fresh;

  modport source (output valid, now_time, speed, goal_distance, autonomous,
                  at_goal, plan_stop, data_fresh, input ready);
  modport sink (input valid, now_time, speed, goal_distance, autonomous,
                at_goal, plan_stop, data_fresh, output ready);
endinterface

interface asd_out_if;
  logic valid;
  logic ready;
  logic abnormal_stop;

  modport source (output valid, abnormal_stop, input ready);
  modport sink (input valid, abnormal_stop, output ready);
endinterface

interface asd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asd_pkg::CfgIdxW-1:0]   index;
  logic [asd_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/asd_cfg_regs.sv
`default_nettype none
module asd_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  asd_cfg_if.sink        cfg_i,
  output asd_pkg::cfg_t  cfg_o
);

  asd_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_speed          <= asd_pkg::StopSpeedRst;
      cfg_q.rearm_speed         <= asd_pkg::RearmSpeedRst;
      cfg_q.goal_distance_limit <= asd_pkg::GoalLimitRst;
      cfg_q.hold_time           <= asd_pkg::HoldTimeRst;
      cfg_q.rearm_time          <= asd_pkg::RearmTimeRst;
      cfg_q.grace_time          <= asd_pkg::GraceTimeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        asd_pkg::CfgStopSpeed:  cfg_q.stop_speed <= cfg_i.data[asd_pkg::MagW-1:0];
        asd_pkg::CfgRearmSpeed: cfg_q.rearm_speed <= cfg_i.data[asd_pkg::MagW-1:0];
        asd_pkg::CfgGoalLimit:  cfg_q.goal_distance_limit <= cfg_i.data[asd_pkg::DistW-1:0];
        asd_pkg::CfgHoldTime:   cfg_q.hold_time <= cfg_i.data[asd_pkg::DurW-1:0];
        asd_pkg::CfgRearmTime:  cfg_q.rearm_time <= cfg_i.data[asd_pkg::DurW-1:0];
        asd_pkg::CfgGraceTime:  cfg_q.grace_time <= cfg_i.data[asd_pkg::DurW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/abnormal_stop_detector.sv
// Abnormal-stop detector: one result word for every sample word.
// A sample is taken into the sample register, then its result into the result
// register. Throughput: one sample per cycle while out ready is high; a waiting
// result holds one sample behind it, then input ready drops.
// Reset (rst_ni low, asynchronous): pipeline empty, detector armed, timers and
// grace window cleared, configuration back to its default values.
`default_nettype none
module abnormal_stop_detector (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  asd_in_if.sink     in_i,
  asd_cfg_if.sink    cfg_i,
  asd_out_if.source  out_o
);

  asd_pkg::cfg_t    cfg;
  asd_pkg::sample_t smp_q;
  logic             smp_valid_q;
  logic             res_valid_q;
  logic             res_stop_q;
  logic             fire;

  logic                      armed_q, armed_d;
  logic                      prev_planned_q;
  logic [asd_pkg::TimeW-1:0] grace_until_q, grace_until_d;
  logic                      stop_v_q, stop_v_d;
  logic [asd_pkg::TimeW-1:0] stop_t_q, stop_t_d;
  logic                      move_v_q, move_v_d;
  logic [asd_pkg::TimeW-1:0] move_t_q, move_t_d;
  logic                      hit;

  logic [asd_pkg::SpeedW-1:0] neg_speed;
  logic [asd_pkg::MagW-1:0]   mag;
  logic                       plan_end;
  logic [asd_pkg::TimeW:0]    grace_sum;
  logic                       in_grace;
  logic                       leave;
  logic                       suppress;
  logic                       moving;
  logic                       slow;
  logic [asd_pkg::TimeW-1:0]  start_sel;
  logic [asd_pkg::DurW-1:0]   limit_sel;
  logic [asd_pkg::TimeW:0]    diff;
  logic                       elapsed;

  asd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign fire       = smp_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !smp_valid_q || fire;

  assign out_o.valid         = res_valid_q;
  assign out_o.abnormal_stop = res_stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        smp_valid_q <= in_i.valid;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      smp_q.now_time      <= in_i.now_time;
      smp_q.speed         <= in_i.speed;
      smp_q.goal_distance <= in_i.goal_distance;
      smp_q.autonomous    <= in_i.autonomous;
      smp_q.at_goal       <= in_i.at_goal;
      smp_q.plan_stop     <= in_i.plan_stop;
      smp_q.data_fresh    <= in_i.data_fresh;
    end
    if (fire) begin
      res_stop_q <= hit;
      stop_t_q   <= stop_t_d;
      move_t_q   <= move_t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q        <= 1'b1;
      prev_planned_q <= 1'b0;
      grace_until_q  <= '0;
      stop_v_q       <= 1'b0;
      move_v_q       <= 1'b0;
    end else if (fire) begin
      armed_q        <= armed_d;
      prev_planned_q <= smp_q.plan_stop;
      grace_until_q  <= grace_until_d;
      stop_v_q       <= stop_v_d;
      move_v_q       <= move_v_d;
    end
  end

  // absolute speed, most negative code clamps to full scale
  assign neg_speed = -smp_q.speed;
  always_comb begin
    if (!smp_q.speed[asd_pkg::SpeedW-1]) begin
      mag = smp_q.speed[asd_pkg::MagW-1:0];
    end else if (neg_speed[asd_pkg::SpeedW-1]) begin
      mag = {asd_pkg::MagW{1'b1}};
    end else begin
      mag = neg_speed[asd_pkg::MagW-1:0];
    end
  end

  assign plan_end  = prev_planned_q && !smp_q.plan_stop;
  assign grace_sum = {1'b0, smp_q.now_time}
                   + {{(asd_pkg::TimeW + 1 - asd_pkg::DurW){1'b0}}, cfg.grace_time};

  always_comb begin
    grace_until_d = grace_until_q;
    if (plan_end) begin
      grace_until_d = grace_sum[asd_pkg::TimeW] ? asd_pkg::TimeMax
                                                : grace_sum[asd_pkg::TimeW-1:0];
    end
  end

  // window just opened: now < sat(now + grace) without waiting on the add
  assign in_grace = plan_end ? ((cfg.grace_time != '0) && (smp_q.now_time != asd_pkg::TimeMax))
                             : (smp_q.now_time < grace_until_q);

  assign leave    = !smp_q.autonomous || smp_q.at_goal || smp_q.plan_stop;
  assign suppress = !smp_q.data_fresh
                 || (smp_q.goal_distance <= cfg.goal_distance_limit) || in_grace;
  assign moving   = mag > cfg.rearm_speed;
  assign slow     = mag > cfg.stop_speed;

  assign start_sel = moving ? (move_v_q ? move_t_q : smp_q.now_time) : stop_t_q;
  assign limit_sel = moving ? cfg.rearm_time : cfg.hold_time;
  assign diff      = {1'b0, smp_q.now_time} - {1'b0, start_sel};
  assign elapsed   = !diff[asd_pkg::TimeW]
                  && (diff[asd_pkg::TimeW-1:0]
                      >= {{(asd_pkg::TimeW - asd_pkg::DurW){1'b0}}, limit_sel});

  always_comb begin
    armed_d  = armed_q;
    stop_v_d = stop_v_q;
    stop_t_d = stop_t_q;
    move_v_d = move_v_q;
    move_t_d = move_t_q;
    hit      = 1'b0;
    if (leave) begin
      armed_d  = 1'b1;
      stop_v_d = 1'b0;
      move_v_d = 1'b0;
    end else if (suppress) begin
      stop_v_d = 1'b0;
      move_v_d = 1'b0;
    end else if (moving) begin
      stop_v_d = 1'b0;
      if (!move_v_q) begin
        move_v_d = 1'b1;
        move_t_d = smp_q.now_time;
      end
      if (!armed_q && elapsed) begin
        armed_d = 1'b1;
      end
    end else begin
      move_v_d = 1'b0;
      if (slow) begin
        stop_v_d = 1'b0;
      end else if (!stop_v_q) begin
        stop_v_d = 1'b1;
        stop_t_d = smp_q.now_time;
      end else if (armed_q && elapsed) begin
        armed_d = 1'b0;
        hit     = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
